// File: sv/ecrt_pkg.sv
package ecrt_pkg;

   localparam int ENTRY_BITS     = 42;
   localparam int NUM_ENTRIES    = 6;
   localparam int INDEX_BITS     = 3;
   localparam int BP_BITS        = 18;
   localparam int BP_MSB         = 41;
   localparam int BP_LSB         = 24;
   localparam int DIFF_BITS      = 18;
   localparam int CHAN_BITS      = 8;
   localparam int ELEV_BITS      = 16;

   localparam logic [INDEX_BITS-1:0] ENTRY_FIRST = 3'd0;
   localparam logic [INDEX_BITS-1:0] ENTRY_LAST  = 3'd5;

   localparam logic [CHAN_BITS:0]       FLOOD_ADD   = 9'd90;
   localparam logic [CHAN_BITS:0]       FLOOD_LIMIT = 9'd255;
   localparam logic signed [ELEV_BITS-1:0] BAND_BLUE  = 16'sd10;
   localparam logic signed [ELEV_BITS-1:0] BAND_GREEN = 16'sd50;
   localparam logic signed [ELEV_BITS-1:0] BAND_RED   = 16'sd100;

   typedef logic [ENTRY_BITS-1:0] entry_type;
   typedef logic [INDEX_BITS-1:0] index_type;

   localparam entry_type RAMP_RESET [NUM_ENTRIES] = '{
      42'd4397991762478, 42'd24042606, 42'd1352071910,
      42'd5043707080, 42'd6725353130, 42'd13438203020
   };

   // Blue sits in bits 23:16, green in 15:8, red in 7:0.
   function automatic logic [CHAN_BITS-1:0] entry_blue(input entry_type v);
      return v[23:16];
   endfunction

   function automatic logic [CHAN_BITS-1:0] entry_green(input entry_type v);
      return v[15:8];
   endfunction

   function automatic logic [CHAN_BITS-1:0] entry_red(input entry_type v);
      return v[7:0];
   endfunction

   function automatic logic signed [BP_BITS-1:0] entry_bp(input entry_type v);
      return signed'(v[BP_MSB:BP_LSB]);
   endfunction

endpackage

// File: sv/ecrt_if.sv
interface ecrt_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] elevation;
   logic [7:0]         src_blue;
   logic [7:0]         src_green;
   logic [7:0]         src_red;

   modport source (output valid, elevation, src_blue, src_green, src_red, input ready);
   modport sink   (input valid, elevation, src_blue, src_green, src_red, output ready);
endinterface

interface ecrt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] heat_blue;
   logic [7:0] heat_green;
   logic [7:0] heat_red;
   logic [7:0] flood_blue;
   logic [7:0] flood_green;
   logic [7:0] flood_red;

   modport source (output valid, heat_blue, heat_green, heat_red,
                   flood_blue, flood_green, flood_red, input ready);
   modport sink   (input valid, heat_blue, heat_green, heat_red,
                   flood_blue, flood_green, flood_red, output ready);
endinterface

// File: sv/elevation_color_ramp_tint_core.sv
// Elevation color ramp and flood tint. Every transfer on req carries one elevation
// sample (signed whole meters) and one source BGR pixel, and produces exactly one
// transfer on rsp with a heat-map color and a flood-tinted copy of the pixel. The heat
// color comes from six breakpoint/color entries written through the csr port (index
// 0..5, breakpoint in bits 41:24 as signed quarter-meters, BGR in bits 23:0); values
// below the first or above the last breakpoint take the end color, and values between
// are blended with a WEIGHT_BITS-bit weight. The block accepts one pixel per clock unless
// a stalled rsp has filled the pipeline. The edge of an input transfer registers the
// segment selection made from the request, WEIGHT_BITS stages then each resolve
// one weight bit in the pipelined restoring divider that forms the weight, and a final
// stage registers the blend into the output register. Each stage advances whenever the
// stage after it is empty or moving, so bubbles are squeezed out and a stalled rsp does
// not stop req until the pipeline is full. Write the csr registers only while no pixel
// is in flight.
module elevation_color_ramp_tint_core #(
   parameter int WEIGHT_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   ecrt_req_if.sink                     req,
   ecrt_rsp_if.source                   rsp,
   input  logic                         csr_we,
   input  ecrt_pkg::index_type          csr_index,
   input  ecrt_pkg::entry_type          csr_wdata
);
   import ecrt_pkg::*;

   // Stage 0 selects the segment, stages 1..WEIGHT_BITS each resolve one weight bit,
   // and the last stage is the output register.
   localparam int DIV_STAGES = WEIGHT_BITS;
   localparam int NUM_STAGES = WEIGHT_BITS + 2;
   localparam int PROD_BITS  = WEIGHT_BITS + 1 + CHAN_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;

   typedef struct packed {
      index_type              idx_lo;
      index_type              idx_hi;
      logic [DIFF_BITS-1:0]   rem;
      logic [DIFF_BITS-1:0]   den;
      logic [WEIGHT_BITS-1:0] quo;
      logic [CHAN_BITS-1:0]   flood_blue;
      logic [CHAN_BITS-1:0]   flood_green;
      logic [CHAN_BITS-1:0]   flood_red;
   } pipe_type;

   entry_type ramp_ff [NUM_ENTRIES];

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] advance;
   pipe_type              pipe_ff [DIV_STAGES+1];
   pipe_type              pipe_in [DIV_STAGES+1];

   logic [CHAN_BITS-1:0]  heat_blue_ff, heat_green_ff, heat_red_ff;
   logic [CHAN_BITS-1:0]  flood_blue_ff, flood_green_ff, flood_red_ff;
   logic [CHAN_BITS-1:0]  heat_blue_in, heat_green_in, heat_red_in;

   // Configuration registers. Writes past the last entry are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_ENTRIES; k++) begin
            ramp_ff[k] <= RAMP_RESET[k];
         end
      end else if (csr_we && (csr_index <= ENTRY_LAST)) begin
         ramp_ff[csr_index] <= csr_wdata;
      end
   end

   // A stage takes new contents when it is empty or its contents move on.
   assign advance[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp.ready;
   for (genvar s = 0; s < NUM_STAGES - 1; s++) begin : g_adv
      assign advance[s] = !valid_ff[s] || advance[s+1];
   end

   assign req.ready = advance[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (advance[0]) begin
            valid_ff[0] <= req.valid;
         end
         for (int s = 1; s < NUM_STAGES; s++) begin
            if (advance[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // Segment selection. The elevation is scaled to quarter-meters and compared with
   // every breakpoint at once; the first upper breakpoint above it names the segment.
   // Clamped cases use a zero numerator so the weight comes out zero and the blend
   // returns the low color unchanged.
   logic signed [BP_BITS-1:0]   e4;
   logic signed [BP_BITS-1:0]   bp [NUM_ENTRIES];
   logic [NUM_ENTRIES-2:0]      below_hi;
   index_type                   seg_lo;
   index_type                   seg_hi;
   logic                        seg_found;
   logic signed [BP_BITS:0]     num_wide;
   logic signed [BP_BITS:0]     den_wide;
   logic [CHAN_BITS:0]          sum_blue, sum_green, sum_red;
   logic                        band_blue, band_green, band_red;

   always_comb begin
      e4 = {req.elevation, 2'b00};
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         bp[k] = entry_bp(ramp_ff[k]);
      end
      for (int k = 0; k < NUM_ENTRIES - 1; k++) begin
         below_hi[k] = (e4 < bp[k+1]);
      end

      seg_found = 1'b0;
      seg_lo    = ENTRY_LAST;
      for (int k = NUM_ENTRIES - 2; k >= 0; k--) begin
         if (below_hi[k]) begin
            seg_found = 1'b1;
            seg_lo    = INDEX_BITS'(k);
         end
      end

      if (e4 < bp[0]) begin
         seg_found = 1'b0;
         seg_lo    = ENTRY_FIRST;
      end else if (e4 > bp[NUM_ENTRIES-1]) begin
         seg_found = 1'b0;
         seg_lo    = ENTRY_LAST;
      end

      seg_hi   = seg_found ? (seg_lo + INDEX_BITS'(1)) : seg_lo;
      num_wide = '0;
      den_wide = (BP_BITS+1)'(1);
      if (seg_found) begin
         num_wide = (BP_BITS+1)'(e4) - (BP_BITS+1)'(bp[seg_lo]);
         den_wide = (BP_BITS+1)'(bp[seg_hi]) - (BP_BITS+1)'(bp[seg_lo]);
      end

      // Flood tint: at most one channel, chosen by elevation band, only if the sum stays under 255.
      band_blue  = (req.elevation < BAND_BLUE);
      band_green = !band_blue && (req.elevation < BAND_GREEN);
      band_red   = !band_blue && !band_green && (req.elevation < BAND_RED);
      sum_blue   = {1'b0, req.src_blue}  + FLOOD_ADD;
      sum_green  = {1'b0, req.src_green} + FLOOD_ADD;
      sum_red    = {1'b0, req.src_red}   + FLOOD_ADD;

      pipe_in[0].idx_lo      = seg_lo;
      pipe_in[0].idx_hi      = seg_hi;
      pipe_in[0].rem         = num_wide[DIFF_BITS-1:0];
      pipe_in[0].den         = den_wide[DIFF_BITS-1:0];
      pipe_in[0].quo         = '0;
      pipe_in[0].flood_blue  = (band_blue && (sum_blue < FLOOD_LIMIT)) ?
                               sum_blue[CHAN_BITS-1:0] : req.src_blue;
      pipe_in[0].flood_green = (band_green && (sum_green < FLOOD_LIMIT)) ?
                               sum_green[CHAN_BITS-1:0] : req.src_green;
      pipe_in[0].flood_red   = (band_red && (sum_red < FLOOD_LIMIT)) ?
                               sum_red[CHAN_BITS-1:0] : req.src_red;
   end

   // Restoring division, one quotient bit per stage. For an ascending table the remainder
   // stays below the divisor, so the quotient is the weight and never reaches one.
   for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
      logic [DIFF_BITS:0] shifted;
      logic [DIFF_BITS:0] diff;
      logic               take;

      always_comb begin
         shifted    = {pipe_ff[j-1].rem, 1'b0};
         diff       = shifted - {1'b0, pipe_ff[j-1].den};
         take       = (shifted >= {1'b0, pipe_ff[j-1].den});
         pipe_in[j]     = pipe_ff[j-1];
         pipe_in[j].rem = take ? diff[DIFF_BITS-1:0] : shifted[DIFF_BITS-1:0];
         pipe_in[j].quo = {pipe_ff[j-1].quo[WEIGHT_BITS-2:0], take};
      end
   end

   for (genvar s = 0; s <= DIV_STAGES; s++) begin : g_pipe
      always_ff @(posedge clock) begin
         if (advance[s]) begin
            pipe_ff[s] <= pipe_in[s];
         end
      end
   end

   // Blend: ((one - w) * c_lo + w * c_hi) >> WEIGHT_BITS per channel. Entries must not
   // change while pixels are in flight; the block does not enforce this. Colors are read here by index.
   logic [WEIGHT_BITS:0] w_hi;
   logic [WEIGHT_BITS:0] w_lo;
   entry_type            col_lo;
   entry_type            col_hi;
   logic [SUM_BITS-1:0]  mix_blue, mix_green, mix_red;

   always_comb begin
      w_hi   = {1'b0, pipe_ff[DIV_STAGES].quo};
      w_lo   = {1'b1, {WEIGHT_BITS{1'b0}}} - w_hi;
      col_lo = ramp_ff[pipe_ff[DIV_STAGES].idx_lo];
      col_hi = ramp_ff[pipe_ff[DIV_STAGES].idx_hi];
      mix_blue  = SUM_BITS'(PROD_BITS'(w_lo) * PROD_BITS'(entry_blue(col_lo)))
                + SUM_BITS'(PROD_BITS'(w_hi) * PROD_BITS'(entry_blue(col_hi)));
      mix_green = SUM_BITS'(PROD_BITS'(w_lo) * PROD_BITS'(entry_green(col_lo)))
                + SUM_BITS'(PROD_BITS'(w_hi) * PROD_BITS'(entry_green(col_hi)));
      mix_red   = SUM_BITS'(PROD_BITS'(w_lo) * PROD_BITS'(entry_red(col_lo)))
                + SUM_BITS'(PROD_BITS'(w_hi) * PROD_BITS'(entry_red(col_hi)));
      heat_blue_in  = mix_blue[WEIGHT_BITS +: CHAN_BITS];
      heat_green_in = mix_green[WEIGHT_BITS +: CHAN_BITS];
      heat_red_in   = mix_red[WEIGHT_BITS +: CHAN_BITS];
   end

   always_ff @(posedge clock) begin
      if (advance[NUM_STAGES-1]) begin
         heat_blue_ff   <= heat_blue_in;
         heat_green_ff  <= heat_green_in;
         heat_red_ff    <= heat_red_in;
         flood_blue_ff  <= pipe_ff[DIV_STAGES].flood_blue;
         flood_green_ff <= pipe_ff[DIV_STAGES].flood_green;
         flood_red_ff   <= pipe_ff[DIV_STAGES].flood_red;
      end
   end

   assign rsp.valid       = valid_ff[NUM_STAGES-1];
   assign rsp.heat_blue   = heat_blue_ff;
   assign rsp.heat_green  = heat_green_ff;
   assign rsp.heat_red    = heat_red_ff;
   assign rsp.flood_blue  = flood_blue_ff;
   assign rsp.flood_green = flood_green_ff;
   assign rsp.flood_red   = flood_red_ff;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ecrt_pkg::*;

   localparam int WEIGHT_BITS      = 8;
   localparam int RANDOM_PHASES    = 8;
   localparam int PIXELS_PER_PHASE = 50;
   localparam int IDLE_PERCENT     = 29;
   localparam int RESET_CYCLES     = 10;
   // Watchdog limit, set far above the length of the slowest legal run.
   localparam int CYCLE_LIMIT      = 200000;

   // One pixel as it travels on the request channel.
   typedef struct packed {
      logic [ELEV_BITS-1:0] elevation;
      logic [CHAN_BITS-1:0] blue;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] red;
   } pixel_type;

   // The six output channels of one response transfer.
   typedef struct packed {
      logic [CHAN_BITS-1:0] heat_blue;
      logic [CHAN_BITS-1:0] heat_green;
      logic [CHAN_BITS-1:0] heat_red;
      logic [CHAN_BITS-1:0] flood_blue;
      logic [CHAN_BITS-1:0] flood_green;
      logic [CHAN_BITS-1:0] flood_red;
   } colors_type;

   // Every input of the block starts at a known value and is only changed with
   // nonblocking assignments on the rising edge.
   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   pixel_type            req_pixel = '0;
   logic                 rsp_ready = 1'b0;
   logic                 csr_we    = 1'b0;
   index_type            csr_index = '0;
   entry_type            csr_wdata = '0;

   // When calm is set neither side idles, which gives one long stretch of
   // back-to-back transfers.
   bit                   calm = 1'b0;
   int                   errors = 0;
   int                   results_seen = 0;
   int unsigned          cycle_count = 0;

   // Local copy of the six ramp registers, kept in step with every csr write.
   entry_type            ramp [NUM_ENTRIES];

   pixel_type            pixel_queue [$];
   colors_type           expected_colors [$];
   colors_type           got_colors;
   colors_type           want_colors;

   ecrt_req_if req_bus ();
   ecrt_rsp_if rsp_bus ();

   assign req_bus.valid     = req_valid;
   assign req_bus.elevation = req_pixel.elevation;
   assign req_bus.src_blue  = req_pixel.blue;
   assign req_bus.src_green = req_pixel.green;
   assign req_bus.src_red   = req_pixel.red;
   assign rsp_bus.ready     = rsp_ready;

   elevation_color_ramp_tint_core #(
      .WEIGHT_BITS (WEIGHT_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Color prediction
   // ------------------------------------------------------------------

   // Breakpoint of a ramp entry, sign-extended from 18 bits.
   function automatic int bp_of(input entry_type v);
      logic signed [BP_BITS-1:0] bp;
      bp = v[BP_MSB:BP_LSB];
      return bp;
   endfunction

   // Channel 0 is blue (bits 23:16), 1 is green, 2 is red (bits 7:0).
   function automatic logic [CHAN_BITS-1:0] chan_of(input entry_type v, input int ch);
      return v[(16 - 8 * ch) +: 8];
   endfunction

   function automatic entry_type make_entry(input int bp, input logic [CHAN_BITS-1:0] b,
                                            input logic [CHAN_BITS-1:0] g,
                                            input logic [CHAN_BITS-1:0] r);
      logic [BP_BITS-1:0] bp_bits;
      bp_bits = BP_BITS'(bp);
      return {bp_bits, b, g, r};
   endfunction

   // The tinted channel takes +90 only when the sum stays below 255.
   function automatic logic [CHAN_BITS-1:0] flood_of(input logic [CHAN_BITS-1:0] src,
                                                     input bit chosen);
      logic [CHAN_BITS:0] sum;
      sum = {1'b0, src} + FLOOD_ADD;
      if (chosen && sum < FLOOD_LIMIT) return sum[CHAN_BITS-1:0];
      return src;
   endfunction

   // Works out both colors of one pixel against the current ramp table. An end
   // color is expressed as a blend of an entry with itself at weight zero.
   function automatic colors_type predict_colors(input pixel_type px);
      colors_type                  res;
      logic signed [ELEV_BITS-1:0] e16;
      int                          elev, e4, seg, k, ch, lo, hi;
      longint                      num, den, w, one;
      entry_type                   lo_ent, hi_ent;
      logic [CHAN_BITS-1:0]        heat [3];

      e16  = px.elevation;
      elev = e16;
      e4   = elev * 4;
      one  = longint'(1) << WEIGHT_BITS;
      seg  = -1;
      w    = 0;

      for (k = 0; k < NUM_ENTRIES - 1; k++)
         if (seg < 0 && e4 < bp_of(ramp[k + 1])) seg = k;

      if (e4 < bp_of(ramp[0])) begin
         lo_ent = ramp[0];
         hi_ent = ramp[0];
      end else if (e4 > bp_of(ramp[NUM_ENTRIES - 1]) || seg < 0) begin
         // Above the top, exactly at the top, or no segment in a table that
         // does not ascend: all of these take the last color.
         lo_ent = ramp[NUM_ENTRIES - 1];
         hi_ent = ramp[NUM_ENTRIES - 1];
      end else begin
         lo_ent = ramp[seg];
         hi_ent = ramp[seg + 1];
         lo  = bp_of(lo_ent);
         hi  = bp_of(hi_ent);
         num = longint'(e4 - lo);
         den = longint'(hi - lo);
         w   = (num << WEIGHT_BITS) / den;
         if (w > one) w = one;
      end

      for (ch = 0; ch < 3; ch++)
         heat[ch] = CHAN_BITS'(((one - w) * longint'(chan_of(lo_ent, ch)) +
                                w * longint'(chan_of(hi_ent, ch))) >>> WEIGHT_BITS);

      res.heat_blue   = heat[0];
      res.heat_green  = heat[1];
      res.heat_red    = heat[2];
      res.flood_blue  = flood_of(px.blue,  elev < BAND_BLUE);
      res.flood_green = flood_of(px.green, elev >= BAND_BLUE && elev < BAND_GREEN);
      res.flood_red   = flood_of(px.red,   elev >= BAND_GREEN && elev < BAND_RED);
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("ERROR at cycle %0d: %s", cycle_count, what);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [CHAN_BITS-1:0] got,
                              input logic [CHAN_BITS-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s is %0d, expected %0d",
                                   results_seen, name, got, want));
   endtask

   // ------------------------------------------------------------------
   // Driver: presents pixels from pixel_queue and records the expected colors
   // of each pixel at the edge where its transfer takes place. Valid is held
   // until the transfer completes, and idles at random between pixels.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_bus.ready)
            expected_colors.insert(expected_colors.size(), predict_colors(req_pixel));
         if (!req_valid || req_bus.ready) begin
            if (pixel_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_pixel <= pixel_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every response transfer is compared with the oldest expectation.
   // Ready is stalled at random except while calm is set.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            got_colors.heat_blue   = rsp_bus.heat_blue;
            got_colors.heat_green  = rsp_bus.heat_green;
            got_colors.heat_red    = rsp_bus.heat_red;
            got_colors.flood_blue  = rsp_bus.flood_blue;
            got_colors.flood_green = rsp_bus.flood_green;
            got_colors.flood_red   = rsp_bus.flood_red;
            if (expected_colors.size() == 0) begin
               report_mismatch("response transfer with no expectation waiting");
            end else begin
               want_colors = expected_colors.pop_front();
               check_field("heat_blue",   got_colors.heat_blue,   want_colors.heat_blue);
               check_field("heat_green",  got_colors.heat_green,  want_colors.heat_green);
               check_field("heat_red",    got_colors.heat_red,    want_colors.heat_red);
               check_field("flood_blue",  got_colors.flood_blue,  want_colors.flood_blue);
               check_field("flood_green", got_colors.flood_green, want_colors.flood_green);
               check_field("flood_red",   got_colors.flood_red,   want_colors.flood_red);
            end
            results_seen++;
         end
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: a hung pipeline or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   task automatic add_pixel(input int elev, input int b, input int g, input int r);
      pixel_type px;
      px.elevation = ELEV_BITS'(elev);
      px.blue      = CHAN_BITS'(b);
      px.green     = CHAN_BITS'(g);
      px.red       = CHAN_BITS'(r);
      pixel_queue.insert(pixel_queue.size(), px);
   endtask

   // Source channels lean toward the region where +90 crosses 255.
   function automatic int pick_channel();
      if ($urandom_range(3) == 0) return 160 + $urandom_range(10);
      return $urandom_range(255);
   endfunction

   // The block is idle once nothing is queued, nothing is being offered and
   // every expected result has come back.
   task automatic wait_idle();
      @(negedge clock);
      while (pixel_queue.size() != 0 || req_valid || expected_colors.size() != 0)
         @(negedge clock);
   endtask

   // Writes one register; out-of-range indexes are ignored by the block and
   // so are not mirrored in the local table.
   task automatic write_ramp(input index_type idx, input entry_type val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx <= ENTRY_LAST) ramp[idx] = val;
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int        phase, k, bp, elev;
      int        bps [$];
      entry_type noise;
      entry_type extreme_ramp [NUM_ENTRIES];

      for (k = 0; k < NUM_ENTRIES; k++) ramp[k] = RAMP_RESET[k];

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset table: breakpoints at -4, 1, 80, 300, 400 and 800 quarter-meters.
      // Covers the field extremes, the exact bottom and top breakpoints, every
      // flood band edge, and source channels on both sides of the 255 limit.
      add_pixel(-32768,   0,   0,   0);
      add_pixel( 32767, 255, 255, 255);
      add_pixel(    -2, 164, 164, 164);
      add_pixel(    -1, 165,   0,   0);
      add_pixel(     0, 255,  10,  10);
      add_pixel(     9,   0,   0,   0);
      add_pixel(    10,   0, 164,   0);
      add_pixel(    10,   0, 165,   0);
      add_pixel(    20, 128, 128, 128);
      add_pixel(    49,   0, 255,   0);
      add_pixel(    50,   0,   0, 164);
      add_pixel(    99,   0,   0, 165);
      add_pixel(   100,   0,   0,   0);
      add_pixel(   199,   1,   2,   3);
      add_pixel(   200,  50,  60,  70);
      add_pixel(   201, 255,   0, 255);

      // Extreme breakpoints and colors, plus writes to the two unused indexes
      // that must leave the table untouched.
      wait_idle();
      extreme_ramp = '{make_entry(-131072,   0,   0,   0),
                       make_entry( -65536, 255, 255, 255),
                       make_entry(      0,   0, 255,   0),
                       make_entry(      4, 255,   0, 255),
                       make_entry(  65536,   0,   0,   0),
                       make_entry( 131071, 255, 255, 255)};
      for (k = 0; k < NUM_ENTRIES; k++)
         write_ramp(index_type'(k), extreme_ramp[k]);
      noise = entry_type'({$urandom, $urandom});
      write_ramp(ENTRY_LAST + 3'd1, noise);
      write_ramp(ENTRY_LAST + 3'd2, '1);
      end_writes();
      add_pixel(-32768,  12,  34,  56);
      add_pixel(-16384, 200, 100,  50);
      add_pixel(     0,  90,  90,  90);
      add_pixel(     1, 255, 255, 255);
      add_pixel( 32767, 164, 165, 166);

      // All-zero and all-one registers in turn: a table that does not ascend.
      wait_idle();
      for (k = 0; k < NUM_ENTRIES; k++)
         write_ramp(index_type'(k), (k % 2 == 0) ? entry_type'('0) : entry_type'('1));
      end_writes();
      add_pixel(-1, 10, 20, 30);
      add_pixel( 0, 40, 50, 60);
      add_pixel( 5, 70, 80, 90);

      // Random phases cycle through four kinds of table: wide and ascending,
      // narrow around the flood bands, unsorted, and ascending with repeated
      // breakpoints. Each breakpoint is rounded down to whole meters at random, so that
      // pixels can hit them exactly.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         calm = 1'b0;
         bps.delete();
         for (k = 0; k < NUM_ENTRIES; k++) begin
            if (phase % 4 == 1) bp = int'($urandom_range(1600)) - 400;
            else                bp = int'($urandom_range(262143)) - 131072;
            if ($urandom_range(1)) bp = bp & ~3;
            if (phase % 4 == 3 && k > 0 && $urandom_range(1)) bp = bps[k - 1];
            bps.insert(bps.size(), bp);
         end
         if (phase % 4 != 2) bps.sort();
         for (k = 0; k < NUM_ENTRIES; k++)
            write_ramp(index_type'(k), make_entry(bps[k], CHAN_BITS'($urandom),
                                                  CHAN_BITS'($urandom), CHAN_BITS'($urandom)));
         end_writes();

         // One phase runs with no idling on either side.
         calm = (phase == 3);

         repeat (PIXELS_PER_PHASE) begin
            case ($urandom_range(3))
               0:       elev = int'($urandom_range(400)) - 100;
               1:       elev = int'($urandom_range(65535)) - 32768;
               default: elev = (bp_of(ramp[$urandom_range(NUM_ENTRIES - 1)]) >>> 2)
                               + int'($urandom_range(2)) - 1;
            endcase
            add_pixel(elev, pick_channel(), pick_channel(), pick_channel());
         end
      end

      // Drain: wait for every expected result, then let the pipeline run on so
      // that any stray extra response is caught.
      wait_idle();
      calm = 1'b0;
      repeat (WEIGHT_BITS + 6) @(posedge clock);
      if (expected_colors.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_colors.size()));

      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
